@@ hw/rtl/dsdp_pkg.sv @@
// dsdp_pkg: widths, constants and shared types of the delta-sigma DoP packer
// used by dsdp_lane, dsdp_merge and delta_sigma_dop_packer; no dependencies
package dsdp_pkg;

   localparam int ACC_BITS         = 32;
   localparam int INTEGRATOR_COUNT = 4;
   localparam int SAMPLE_BITS      = 24;
   localparam int FB_SHIFT         = 23;
   localparam int BYTE_BITS        = 8;
   localparam int REQ_DATA_BITS    = 2 * SAMPLE_BITS;
   localparam int RSP_DATA_BITS    = 6 * BYTE_BITS;
   // integrator sum before clamping: two accumulator terms and the feedback
   localparam int SUM_BITS         = ACC_BITS + 2;

   // feedback magnitude of 1.0 full scale in accumulator units
   localparam logic signed [ACC_BITS-1:0] FB_UNIT =
      {{(ACC_BITS-FB_SHIFT-1){1'b0}}, 1'b1, {FB_SHIFT{1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   localparam logic [BYTE_BITS-1:0] MARK_EVEN = 8'h05;
   localparam logic [BYTE_BITS-1:0] MARK_ODD  = 8'hFA;
   localparam logic [BYTE_BITS-1:0] BYTE_ONE  = 8'hFF;
   localparam logic [BYTE_BITS-1:0] BYTE_ZERO = 8'h00;

   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // one finished frame as it waits in the output stage
   typedef struct packed {
      logic marker_odd;
      logic right_bit;
      logic left_bit;
   } frame_bits_type;

endpackage

@@ hw/rtl/dsdp_lane.sv @@
// dsdp_lane: one channel of the modulator, a chain of saturating integrators
// and a one-bit quantizer with its feedback state; depends on dsdp_pkg
module dsdp_lane import dsdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  sample_type sample,
   output logic       bit_out
);

   acc_type acc_ff [INTEGRATOR_COUNT];
   acc_type acc_in [INTEGRATOR_COUNT];
   logic    fb_zero_ff;
   logic    fb_pos_ff;
   acc_type fbv;

   always_comb begin
      logic signed [SUM_BITS-1:0] sum;
      acc_type                    feed;
      if (fb_zero_ff) begin
         fbv = '0;
      end else if (fb_pos_ff) begin
         fbv = FB_UNIT;
      end else begin
         fbv = -FB_UNIT;
      end
      feed = ACC_BITS'(sample);
      for (int k = 0; k < INTEGRATOR_COUNT; k++) begin
         sum = SUM_BITS'(acc_ff[k]) + SUM_BITS'(feed) - SUM_BITS'(fbv);
         // top bits disagree with the sign: clamp to the accumulator range
         if (!sum[SUM_BITS-1] && (|sum[SUM_BITS-2:ACC_BITS-1])) begin
            acc_in[k] = ACC_MAX;
         end else if (sum[SUM_BITS-1] && !(&sum[SUM_BITS-2:ACC_BITS-1])) begin
            acc_in[k] = ACC_MIN;
         end else begin
            acc_in[k] = sum[ACC_BITS-1:0];
         end
         feed = acc_in[k];
      end
   end

   // a last integrator of exactly zero quantizes to +1
   assign bit_out = !acc_in[INTEGRATOR_COUNT-1][ACC_BITS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < INTEGRATOR_COUNT; k++) begin
            acc_ff[k] <= '0;
         end
         fb_zero_ff <= 1'b1;
         fb_pos_ff  <= 1'b0;
      end else if (step) begin
         for (int k = 0; k < INTEGRATOR_COUNT; k++) begin
            acc_ff[k] <= acc_in[k];
         end
         fb_zero_ff <= 1'b0;
         fb_pos_ff  <= bit_out;
      end
   end

   a_fb_set_after_step: assert property (@(posedge clock) disable iff (reset)
      step |=> !fb_zero_ff)
      else $error("feedback still zero after an item");

   a_fb_matches_last: assert property (@(posedge clock) disable iff (reset)
      !fb_zero_ff |-> fb_pos_ff == !acc_ff[INTEGRATOR_COUNT-1][ACC_BITS-1])
      else $error("feedback disagrees with last integrator sign");

endmodule

@@ hw/rtl/dsdp_merge.sv @@
// dsdp_merge: joins the lane bits with the shared marker phase, holds results
// in an output register plus skid entry and builds the DoP bytes; uses dsdp_pkg
module dsdp_merge import dsdp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic                     left_bit,
   input  logic                     right_bit,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [RSP_DATA_BITS-1:0] out_data
);

   logic           phase_ff,      phase_in;
   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   frame_bits_type main_ff,       main_in;
   frame_bits_type skid_ff,       skid_in;
   frame_bits_type fresh;
   logic           pop;
   logic [BYTE_BITS-1:0] mark, left_byte, right_byte;

   assign fresh     = '{marker_odd: phase_ff, right_bit: right_bit, left_bit: left_bit};
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      phase_in      = push ? !phase_ff : phase_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = fresh;
            main_valid_in = push;
         end
      end else if (push) begin
         // head is stalled: park the new item in the skid entry
         skid_in       = fresh;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign mark       = main_ff.marker_odd ? MARK_ODD : MARK_EVEN;
   assign left_byte  = main_ff.left_bit  ? BYTE_ONE : BYTE_ZERO;
   assign right_byte = main_ff.right_bit ? BYTE_ONE : BYTE_ZERO;
   assign out_data   = {mark, right_byte, right_byte, mark, left_byte, left_byte};

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a head entry");

   a_phase_toggles: assert property (@(posedge clock) disable iff (reset)
      push |=> phase_ff != $past(phase_ff))
      else $error("marker phase did not advance on an item");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved to head after a take");

endmodule

@@ hw/rtl/delta_sigma_dop_packer.sv @@
// delta_sigma_dop_packer: stereo fourth-order delta-sigma modulator with DoP
// framing; two dsdp_lane instances and one dsdp_merge; uses dsdp_pkg
//
//   channel | dir | ports                              | content
//   req     | in  | req_tvalid req_tready req_tdata    | one stereo PCM frame
//   rsp     | out | rsp_tvalid rsp_tready rsp_tdata    | one DoP word per channel
//
// one item per cycle while req_tready is high; each lane updates its integrator chain in the accept cycle
// each result is registered in the output register, or in the skid entry while the head is stalled
// a two-entry output stage (register plus skid) keeps req_tready high while one
// result waits; req_tready drops only when both entries are full
// synchronous active-high reset clears integrators, feedback and marker phase
module delta_sigma_dop_packer import dsdp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [23:0] left_sample, [47:24] right_sample
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [7:0] left_first_byte, [15:8] left_second_byte, [23:16] left_marker_byte,
   // [31:24] right_first_byte, [39:32] right_second_byte, [47:40] right_marker_byte
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic push;
   logic left_bit, right_bit;

   assign push = req_tvalid && req_tready;

   dsdp_lane u_left (
      .clock   (clock),
      .reset   (reset),
      .step    (push),
      .sample  (req_tdata[SAMPLE_BITS-1:0]),
      .bit_out (left_bit)
   );

   dsdp_lane u_right (
      .clock   (clock),
      .reset   (reset),
      .step    (push),
      .sample  (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .bit_out (right_bit)
   );

   dsdp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .left_bit  (left_bit),
      .right_bit (right_bit),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for delta_sigma_dop_packer; predicts each DoP word
// from its own integrator chains and checks it on rsp; uses dsdp_pkg and the rtl
module tb_top import dsdp_pkg::*;;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 332;

   // rsp_tdata as fields, lowest byte last
   typedef struct packed {
      logic [BYTE_BITS-1:0] right_marker;
      logic [BYTE_BITS-1:0] right_second;
      logic [BYTE_BITS-1:0] right_first;
      logic [BYTE_BITS-1:0] left_marker;
      logic [BYTE_BITS-1:0] left_second;
      logic [BYTE_BITS-1:0] left_first;
   } dop_word_type;

   class dop_scoreboard;
      longint       chain[2][INTEGRATOR_COUNT];
      int           feedback[2];
      bit           odd_phase;
      dop_word_type expected_words[$];
      int           errors;
      int           frames_in;
      int           words_out;
      int           saturations;

      function new();
         foreach (chain[ch, k]) chain[ch][k] = 0;
         feedback[0] = 0;
         feedback[1] = 0;
         odd_phase   = 1'b0;
         errors      = 0;
         frames_in   = 0;
         words_out   = 0;
         saturations = 0;
      endfunction

      // one lane for one frame; returns the data byte of the new bit
      function logic [BYTE_BITS-1:0] modulate(int ch, longint sample);
         longint fb_value;
         longint feed;
         longint sum;
         fb_value = longint'(feedback[ch]) * longint'(FB_UNIT);
         feed     = sample;
         for (int k = 0; k < INTEGRATOR_COUNT; k++) begin
            sum = chain[ch][k] + feed - fb_value;
            if (sum > longint'(ACC_MAX)) begin
               sum = longint'(ACC_MAX);
               saturations++;
            end else if (sum < longint'(ACC_MIN)) begin
               sum = longint'(ACC_MIN);
               saturations++;
            end
            chain[ch][k] = sum;
            feed         = sum;
         end
         // a last stage of exactly zero counts as a one bit
         feedback[ch] = (chain[ch][INTEGRATOR_COUNT-1] >= 0) ? 1 : -1;
         return (feedback[ch] > 0) ? BYTE_ONE : BYTE_ZERO;
      endfunction

      function void note_frame(logic [REQ_DATA_BITS-1:0] data);
         sample_type   left;
         sample_type   right;
         dop_word_type word;
         logic [BYTE_BITS-1:0] mark;
         left  = data[SAMPLE_BITS-1:0];
         right = data[REQ_DATA_BITS-1:SAMPLE_BITS];
         mark  = odd_phase ? MARK_ODD : MARK_EVEN;
         word.left_first   = modulate(0, longint'(left));
         word.left_second  = word.left_first;
         word.left_marker  = mark;
         word.right_first  = modulate(1, longint'(right));
         word.right_second = word.right_first;
         word.right_marker = mark;
         odd_phase = !odd_phase;
         expected_words.push_back(word);
         frames_in++;
      endfunction

      function void compare_byte(string name, logic [BYTE_BITS-1:0] want,
                                 logic [BYTE_BITS-1:0] got);
         if (got !== want) begin
            $error("%s: expected %02h, got %02h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [RSP_DATA_BITS-1:0] data);
         dop_word_type got;
         dop_word_type want;
         got = data;
         words_out++;
         if (expected_words.size() == 0) begin
            $error("word %h with no frame waiting", data);
            errors++;
         end else begin
            want = expected_words.pop_front();
            compare_byte("left_first_byte", want.left_first, got.left_first);
            compare_byte("left_second_byte", want.left_second, got.left_second);
            compare_byte("left_marker_byte", want.left_marker, got.left_marker);
            compare_byte("right_first_byte", want.right_first, got.right_first);
            compare_byte("right_second_byte", want.right_second, got.right_second);
            compare_byte("right_marker_byte", want.right_marker, got.right_marker);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   dop_scoreboard sb = new();

   delta_sigma_dop_packer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // sample both channels at the edge and keep the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_frame(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("nothing moved for %0d cycles", STALL_LIMIT);
            $display("delta_sigma_dop_packer: mismatch");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // valid stays high from one item to the next unless an idle cycle is drawn
   task automatic send_frame(input logic [SAMPLE_BITS-1:0] left,
                             input logic [SAMPLE_BITS-1:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(int kind);
      if (kind < 6) return SAMPLE_BITS'($urandom);
      if (kind < 8) return SAMPLE_BITS'(int'($urandom_range(4096)) - 2048);
      return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
   endfunction

   // mostly fresh frames, some near silence, some long runs at full scale
   task automatic send_random(int count);
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
      int kind;
      int run_len;
      int sent;
      sent = 0;
      while (sent < count) begin
         kind    = $urandom_range(9);
         run_len = (kind >= 8) ? $urandom_range(60, 8) : 1;
         left    = pick_sample(kind);
         right   = pick_sample(kind);
         repeat (run_len) begin
            send_frame(left, right);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero input on the first frame: zero feedback and a quantizer tie
      send_frame(24'h000000, 24'h000000);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      repeat (6) send_frame(24'h7FFFFF, 24'h7FFFFF);
      repeat (6) send_frame(24'h800000, 24'h800000);
      send_frame(24'h000001, 24'hFFFFFF);
      send_frame(24'hFFFFFF, 24'h000001);
      send_frame(24'h555555, 24'hAAAAAA);
      send_frame(24'hAAAAAA, 24'h555555);
      send_frame(24'h000000, 24'h000000);
      send_frame(24'h000000, 24'h000000);
      send_random(PHASE_ITEMS);

      send_idle_pct  = 79;
      send_random(PHASE_ITEMS);

      send_idle_pct  = 0;
      recv_stall_pct = 79;
      send_random(PHASE_ITEMS);

      send_idle_pct  = 25;
      recv_stall_pct = 25;
      send_random(PHASE_ITEMS);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d stereo frames in, %0d dop words checked, %0d integrator clips",
               sb.frames_in, sb.words_out, sb.saturations);
      $display("phases: free flow, sparse sender, stalled receiver, both throttled");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("delta_sigma_dop_packer: match");
      end else begin
         $display("delta_sigma_dop_packer: mismatch");
      end
      $finish;
   end

endmodule
